// ===== src/ssb_pkg.sv =====
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared word types and register indexes for the scaled sprite blitter.
// ----------------------------------------------------------------------------
package ssb_pkg;

  // Input word: load one texel or draw one destination pixel.
  typedef struct packed {
    logic        mode;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [15:0] texel;
  } in_word_t;

  // Result word: one pixel write.
  typedef struct packed {
    logic [8:0]  out_x;
    logic [8:0]  out_y;
    logic [15:0] out_color;
  } out_word_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY     = 3'd6;

  // Width of the scaled numerator src * pos (8 x 9 bits).
  localparam int NUM_W = 17;

endpackage

// ===== src/ssb_div.sv =====
// ----------------------------------------------------------------------------
// ssb_div
// Pipelined restoring divider for both axes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssb_div #(
  parameter int TAG_W = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ssb_pkg::NUM_W-1:0] num_a,
  input  logic [9:0]               den_a,
  input  logic [ssb_pkg::NUM_W-1:0] num_b,
  input  logic [9:0]               den_b,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     out_vld,
  output logic [ssb_pkg::NUM_W-1:0] quo_a,
  output logic [ssb_pkg::NUM_W-1:0] quo_b,
  output logic [TAG_W-1:0]         out_tag
);

  localparam int N = ssb_pkg::NUM_W;
  localparam int RW = 11;

  // Per-stage state: remaining dividend bits shift into the partial remainder.
  logic              vld_r [N+1];
  logic [N-1:0]      qa_r [N+1];
  logic [N-1:0]      qb_r [N+1];
  logic [RW-1:0]     ra_r [N+1];
  logic [RW-1:0]     rb_r [N+1];
  logic [9:0]        da_r [N+1];
  logic [9:0]        db_r [N+1];
  logic [TAG_W-1:0]  tag_r [N+1];

  // Stage zero takes the operands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa_r[0]  <= num_a;
      qb_r[0]  <= num_b;
      ra_r[0]  <= '0;
      rb_r[0]  <= '0;
      da_r[0]  <= den_a;
      db_r[0]  <= den_b;
      tag_r[0] <= in_tag;
    end
  end

  // One subtract-and-compare per stage for each axis.
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [RW-1:0] ta, tb;
    logic          ga, gb;
    assign ta = {ra_r[s][RW-2:0], qa_r[s][N-1]};
    assign tb = {rb_r[s][RW-2:0], qb_r[s][N-1]};
    assign ga = ta >= {1'b0, da_r[s]};
    assign gb = tb >= {1'b0, db_r[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra_r[s+1]  <= ga ? ta - {1'b0, da_r[s]} : ta;
        rb_r[s+1]  <= gb ? tb - {1'b0, db_r[s]} : tb;
        qa_r[s+1]  <= {qa_r[s][N-2:0], ga};
        qb_r[s+1]  <= {qb_r[s][N-2:0], gb};
        da_r[s+1]  <= da_r[s];
        db_r[s+1]  <= db_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign out_vld = vld_r[N];
  assign quo_a   = qa_r[N];
  assign quo_b   = qb_r[N];
  assign out_tag = tag_r[N];

endmodule

// ===== src/scaled_sprite_blit.sv =====
// ----------------------------------------------------------------------------
// scaled_sprite_blit
// Nearest-neighbor scaled sprite blit with color-key transparency.
// ----------------------------------------------------------------------------
// channel | ports                          | carries
// in      | in_valid, in_ready, in_data    | load texel or draw offset word
// out     | out_valid, out_ready, out_data | pixel write word
// cfg     | cfg_we, cfg_idx, cfg_wdata     | register writes, no wait
//
// One word enters per cycle while the pipe advances; the path is a multiplier
// stage, an 18-register divider pipe, a texture stage and the output register.
// Loads travel the same pipe and write the texture store at the stage where
// draws read it, which keeps store accesses in word order without forwarding.
// The whole pipe advances only while the output register is empty or being
// taken. Reset clears the valid bits and the configuration registers; the
// texture store is not cleared.
// ----------------------------------------------------------------------------
module scaled_sprite_blit #(
  parameter int TEX_W = 128,
  parameter int TEX_H = 128,
  parameter int SCREEN_W = 480,
  parameter int SCREEN_H = 272
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssb_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssb_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [ssb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TXW = $clog2(TEX_W);
  localparam int TYW = $clog2(TEX_H);
  localparam int AW  = TXW + TYW;
  localparam int N   = ssb_pkg::NUM_W;
  // Tag carried through the divider: load flag, x and y (11 bits each), texel.
  localparam int TAG_W = 39;

  // Configuration registers.
  logic [7:0]  src_w_r, src_h_r;
  logic [9:0]  dst_w_r, dst_h_r;
  logic [9:0]  org_x_r, org_y_r;
  logic [15:0] key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 8'd128;
      src_h_r <= 8'd128;
      dst_w_r <= 10'd128;
      dst_h_r <= 10'd128;
      org_x_r <= '0;
      org_y_r <= '0;
      key_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        ssb_pkg::REG_SRC_W: src_w_r <= cfg_wdata[7:0];
        ssb_pkg::REG_SRC_H: src_h_r <= cfg_wdata[7:0];
        ssb_pkg::REG_DST_W: dst_w_r <= cfg_wdata[9:0];
        ssb_pkg::REG_DST_H: dst_h_r <= cfg_wdata[9:0];
        ssb_pkg::REG_ORG_X: org_x_r <= cfg_wdata[9:0];
        ssb_pkg::REG_ORG_Y: org_y_r <= cfg_wdata[9:0];
        ssb_pkg::REG_KEY:   key_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipe advance: output register empty or drained this cycle.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage M: multiply and range checks; loads carry their texel and address.
  logic                       m_vld_r, m_ld_r;
  logic [N-1:0]               m_na_r, m_nb_r;
  logic [10:0]                m_ax_r, m_ay_r;
  logic [15:0]                m_tx_r;
  logic                       in_acc, in_draw, in_load;
  logic                       draw_ok, ld_in;

  assign in_acc  = in_valid && in_ready;
  assign in_draw = in_data.mode == ssb_pkg::MODE_DRAW;
  assign in_load = in_data.mode == ssb_pkg::MODE_LOAD;
  assign draw_ok = ({1'b0, in_data.pos_x} < dst_w_r) && ({1'b0, in_data.pos_y} < dst_h_r);
  assign ld_in = in_acc && in_load
              && ({23'd0, in_data.pos_x} < 32'(TEX_W))
              && ({23'd0, in_data.pos_y} < 32'(TEX_H));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= (in_acc && in_draw && draw_ok) || ld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ld_r <= in_load;
      m_na_r <= src_w_r * in_data.pos_x;
      m_nb_r <= src_h_r * in_data.pos_y;
      m_ax_r <= in_load ? {2'b00, in_data.pos_x}
                        : {org_x_r[9], org_x_r} + {2'b00, in_data.pos_x};
      m_ay_r <= in_load ? {2'b00, in_data.pos_y}
                        : {org_y_r[9], org_y_r} + {2'b00, in_data.pos_y};
      m_tx_r <= in_data.texel;
    end
  end

  // Divider pipe for both axes.
  logic             d_vld;
  logic [N-1:0]     d_u, d_v;
  logic [TAG_W-1:0] d_tag;
  logic             d_ld;
  logic [10:0]      d_ax, d_ay;
  logic [15:0]      d_tx;

  ssb_div #(.TAG_W(TAG_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (m_vld_r),
    .num_a   (m_na_r),
    .den_a   (dst_w_r),
    .num_b   (m_nb_r),
    .den_b   (dst_h_r),
    .in_tag  ({m_ld_r, m_ax_r, m_ay_r, m_tx_r}),
    .out_vld (d_vld),
    .quo_a   (d_u),
    .quo_b   (d_v),
    .out_tag (d_tag)
  );

  assign d_ld = d_tag[38];
  assign d_ax = d_tag[37:27];
  assign d_ay = d_tag[26:16];
  assign d_tx = d_tag[15:0];

  // Texture store, one write and one read port, both at the divider's output.
  logic [15:0] tex_mem [2**AW];

  always_ff @(posedge clk) begin
    if (adv && d_vld && d_ld) begin
      tex_mem[{d_ay[TYW-1:0], d_ax[TXW-1:0]}] <= d_tx;
    end
  end

  // Stage R: registered texture read.
  logic        r_vld_r, r_in_r;
  logic [10:0] r_ax_r, r_ay_r;
  logic [15:0] r_tex_r;
  logic        rd_in;
  assign rd_in = (32'(d_u) < 32'(TEX_W)) && (32'(d_v) < 32'(TEX_H));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (adv) begin
      r_vld_r <= d_vld && !d_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_tex_r <= tex_mem[{d_v[TYW-1:0], d_u[TXW-1:0]}];
      r_in_r  <= rd_in;
      r_ax_r  <= d_ax;
      r_ay_r  <= d_ay;
    end
  end

  // Output stage: key and screen clip.
  logic [15:0] col;
  logic        on_scr, emit;
  assign col    = r_in_r ? r_tex_r : 16'd0;
  assign on_scr = !r_ax_r[10] && !r_ay_r[10]
               && (32'(r_ax_r) < 32'(SCREEN_W)) && (32'(r_ay_r) < 32'(SCREEN_H));
  assign emit   = r_vld_r && on_scr && (col != key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_x     <= r_ax_r[8:0];
      out_data.out_y     <= r_ay_r[8:0];
      out_data.out_color <= col;
    end
  end

`ifndef SYNTHESIS
  // A stalled result holds its word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A pixel never carries the color key.
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n) && $stable(key_r) |-> out_data.out_color != key_r)
    else $error("keyed color emitted");

  // Input is taken exactly when the pipe advances.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow pipe advance");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scaled sprite blitter. Random texel loads and
// draw offsets pass over several register settings, extremes included, with
// random idle cycles on both channels and one long output stall. A scoreboard
// predicts every pixel write and checks each result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int TW = 128;
  localparam int TH = 128;
  localparam int SW = 480;
  localparam int SH = 272;

  // Scoreboard: own copy of the registers and texture store, and the queue of
  // pixel writes still owed by the block.
  class blit_scoreboard;
    int src_w, src_h, dst_w, dst_h, org_x, org_y, key;
    logic [15:0] tex [0:TW*TH-1];
    bit loaded [0:TW*TH-1];
    ssb_pkg::out_word_t owed [$];
    int errors;

    function new();
      src_w = 128; src_h = 128; dst_w = 128; dst_h = 128;
      org_x = 0; org_y = 0; key = 0; errors = 0;
      foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void set_reg(logic [ssb_pkg::CFG_IDX_W-1:0] idx,
                          logic [ssb_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ssb_pkg::REG_SRC_W: src_w = val[7:0];
        ssb_pkg::REG_SRC_H: src_h = val[7:0];
        ssb_pkg::REG_DST_W: dst_w = val[9:0];
        ssb_pkg::REG_DST_H: dst_h = val[9:0];
        ssb_pkg::REG_ORG_X: org_x = int'($signed(val[9:0]));
        ssb_pkg::REG_ORG_Y: org_y = int'($signed(val[9:0]));
        ssb_pkg::REG_KEY:   key = val;
        default: ;
      endcase
    endfunction

    // Store index a draw at (x, y) would read, or -1 when none is read.
    function int fetch_index(int x, int y);
      int u, v;
      if (x >= dst_w || y >= dst_h) return -1;
      u = src_w * x / dst_w;
      v = src_h * y / dst_h;
      if (u >= TW || v >= TH) return -1;
      return v * TW + u;
    endfunction

    function void note_input(ssb_pkg::in_word_t w);
      int idx, ax, ay;
      logic [15:0] col;
      ssb_pkg::out_word_t r;
      if (w.mode == ssb_pkg::MODE_LOAD) begin
        if (w.pos_x < TW && w.pos_y < TH) begin
          tex[w.pos_y * TW + w.pos_x] = w.texel;
          loaded[w.pos_y * TW + w.pos_x] = 1;
        end
        return;
      end
      if (w.pos_x >= dst_w || w.pos_y >= dst_h) return;
      idx = fetch_index(w.pos_x, w.pos_y);
      col = (idx < 0) ? 16'h0000 : tex[idx];
      if (col == key) return;
      ax = org_x + w.pos_x;
      ay = org_y + w.pos_y;
      if (ax < 0 || ay < 0 || ax >= SW || ay >= SH) return;
      r.out_x = ax[8:0];
      r.out_y = ay[8:0];
      r.out_color = col;
      owed.push_back(r);
    endfunction

    function void check_result(ssb_pkg::out_word_t got);
      ssb_pkg::out_word_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d color=%h", $time,
                 got.out_x, got.out_y, got.out_color);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.out_x !== exp.out_x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, exp.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== exp.out_y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, exp.out_y, got.out_y);
        errors++;
      end
      if (got.out_color !== exp.out_color) begin
        $display("%0t: out_color expected %h actual %h", $time,
                 exp.out_color, got.out_color);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  ssb_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  ssb_pkg::out_word_t out_data;
  logic cfg_we = 0;
  logic [ssb_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  blit_scoreboard sb = new();
  int results_taken = 0;

  scaled_sprite_blit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Send one word after a random gap; returns at the falling edge after it
  // is accepted.
  task automatic send_word(ssb_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic send_load(int x, int y, logic [15:0] c);
    ssb_pkg::in_word_t w;
    w.mode = ssb_pkg::MODE_LOAD;
    w.pos_x = 9'(x);
    w.pos_y = 9'(y);
    w.texel = c;
    send_word(w);
  endtask

  // Draw at (x, y), loading the texel it reads first if it was never loaded.
  task automatic send_draw(int x, int y);
    ssb_pkg::in_word_t w;
    int idx;
    idx = sb.fetch_index(x, y);
    if (idx >= 0 && !sb.loaded[idx])
      send_load(idx % TW, idx / TW,
                16'(($urandom_range(0, 3) == 0) ? sb.key : $urandom));
    w.mode = ssb_pkg::MODE_DRAW;
    w.pos_x = 9'(x);
    w.pos_y = 9'(y);
    w.texel = 16'($urandom);
    send_word(w);
  endtask

  // Write all seven registers once the pipe has drained.
  task automatic write_regs(int sw, int sh, int dw, int dh, int ox, int oy, int k);
    int vals [7];
    vals = '{sw, sh, dw, dh, ox, oy, k};
    in_valid <= 0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1;
      cfg_idx <= i[ssb_pkg::CFG_IDX_W-1:0];
      cfg_wdata <= vals[i][ssb_pkg::CFG_DATA_W-1:0];
      sb.set_reg(i[ssb_pkg::CFG_IDX_W-1:0], vals[i][ssb_pkg::CFG_DATA_W-1:0]);
      @(negedge clk);
    end
    cfg_we <= 0;
  endtask

  // Random words under the current setting: mostly draws inside the rectangle.
  task automatic random_words(int n);
    int x, y, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        if (sel == 0) begin
          x = $urandom_range(0, 511);
          y = $urandom_range(0, 511);
        end else begin
          x = $urandom_range(0, TW - 1);
          y = $urandom_range(0, TH - 1);
        end
        send_load(x, y, 16'(($urandom_range(0, 3) == 0) ? sb.key : $urandom));
      end else begin
        if (sel == 9) begin
          x = $urandom_range(0, 511);
          y = $urandom_range(0, 511);
        end else begin
          x = $urandom_range(0, (sb.dst_w > 0) ? sb.dst_w - 1 : 0);
          y = $urandom_range(0, (sb.dst_h > 0) ? sb.dst_h - 1 : 0);
          if (x > 511) x = 511;
          if (y > 511) y = 511;
        end
        send_draw(x, y);
      end
    end
  endtask

  // Result side: random ready gaps and one long hold-off that backs up the pipe.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = (results_taken == 40) ? 400 : $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0 && results_taken != 40) gap = 0;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      results_taken++;
    end
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus.
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed words under the reset setting.
    send_load(0, 0, 16'hFFFF);
    send_load(127, 127, 16'h0001);
    send_load(127, 0, 16'h0000);
    send_load(0, 127, 16'h8000);
    send_load(511, 511, 16'h1234);
    send_load(128, 5, 16'h5555);
    send_load(5, 128, 16'hAAAA);
    send_draw(0, 0);
    send_draw(127, 127);
    send_draw(127, 0);
    send_draw(0, 127);
    send_draw(128, 0);
    send_draw(0, 128);
    send_draw(511, 511);

    // Source beyond the store, off-screen origins, largest key.
    write_regs(255, 255, 128, 128, 400, 200, 16'hFFFF);
    send_draw(127, 127);
    send_draw(100, 60);
    send_draw(0, 0);
    write_regs(1, 1, 512, 512, -512, -512, 0);
    send_draw(511, 511);
    send_draw(300, 400);
    write_regs(128, 128, 0, 0, 0, 0, 0);
    send_draw(0, 0);
    write_regs(8, 8, 1023, 1023, 511, 511, 16'h0001);
    send_draw(0, 0);
    send_draw(511, 511);

    // Random settings, a few extremes in the mix.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_regs(128, 128, 128, 128, 0, 0, 0);
        1: write_regs(1, 1, 1, 1, 479, 271, 16'hFFFF);
        2: write_regs(255, 255, 512, 512, -100, -100, $urandom);
        3: write_regs(128, 128, 512, 512, 0, 0, 0);
        default:
          write_regs($urandom_range(1, 128), $urandom_range(1, 128),
                     $urandom_range(1, 512), $urandom_range(1, 512),
                     $urandom_range(0, 450) - 50, $urandom_range(0, 300) - 50,
                     $urandom_range(0, 1) ? 0 : $urandom);
      endcase
      random_words(100);
    end

    // Drain, then allow the pipe latency before the verdict.
    in_valid <= 0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ssb_pkg.sv
src/ssb_div.sv
src/scaled_sprite_blit.sv
tb/sv/testbench.sv
